// ===== rtl/pstt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstt_pkg
// Shared types and codes for the priority-sorted task table.
// ----------------------------------------------------------------------------
package pstt_pkg;

  // operation codes
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_UPDATE = 3'd2;
  localparam logic [2:0] OP_LIST   = 3'd3;
  localparam logic [2:0] OP_GROUP  = 3'd4;
  localparam logic [2:0] OP_PRIO   = 3'd5;

  // result codes
  localparam logic [2:0] RC_OK   = 3'd0;
  localparam logic [2:0] RC_DUP  = 3'd1;
  localparam logic [2:0] RC_NOTF = 3'd2;
  localparam logic [2:0] RC_FULL = 3'd3;
  localparam logic [2:0] RC_NONE = 3'd4;

  // status groups listed in order
  localparam logic [1:0] ST_LAST_GROUP = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] task_id;
    logic [2:0]  prio;
    logic [1:0]  task_state;
    logic [31:0] desc_tag;
  } req_t;

  typedef struct packed {
    logic [2:0]  result_code;
    logic        entry_valid;
    logic [15:0] out_id;
    logic [2:0]  out_prio;
    logic [1:0]  out_state;
    logic [31:0] out_desc;
    logic        last;
  } res_t;

  // one stored table entry
  typedef struct packed {
    logic [15:0] id;
    logic [2:0]  prio;
    logic [1:0]  state;
    logic [31:0] desc;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_SHDN
  } state_e;

endpackage

// ===== rtl/pstt_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstt_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pstt_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  pstt_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output pstt_pkg::entry_t rdata_o
);
  import pstt_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pstt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstt_ctrl
// Sequencer: scans the entry store, shifts entries to open or close a gap,
// and produces the result words.
// ----------------------------------------------------------------------------
module pstt_ctrl #(
  parameter int MAX_TASKS = 32,
  parameter int AW        = 5,
  parameter int CW        = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  pstt_pkg::req_t   req_i,
  output logic             busy_o,
  output logic             res_valid_o,
  output pstt_pkg::res_t   res_o,
  output logic             we_o,
  output logic [AW-1:0]    waddr_o,
  output pstt_pkg::entry_t wdata_o,
  output logic             re_o,
  output logic [AW-1:0]    raddr_o,
  input  pstt_pkg::entry_t rdata_i
);
  import pstt_pkg::*;

  state_e         state_q, state_d;
  req_t           req_q, req_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           rv_q, rv_d;
  logic [AW-1:0]  ridx_q, ridx_d;
  logic           found_q, found_d;
  logic [AW-1:0]  fidx_q, fidx_d;
  entry_t         fent_q, fent_d;
  logic           posf_q, posf_d;
  logic [CW-1:0]  pos_q, pos_d;
  logic [1:0]     grp_q, grp_d;
  logic           pend_q, pend_d;
  entry_t         pent_q, pent_d;
  logic           vld_q, vld_d;
  res_t           res_q, res_d;
  logic           match;
  entry_t         new_ent;

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      rv_q    <= 1'b0;
      vld_q   <= 1'b0;
      found_q <= 1'b0;
      posf_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
      vld_q   <= vld_d;
      found_q <= found_d;
      posf_q  <= posf_d;
      pend_q  <= pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    cnt_q  <= cnt_d;
    ridx_q <= ridx_d;
    fidx_q <= fidx_d;
    fent_q <= fent_d;
    pos_q  <= pos_d;
    grp_q  <= grp_d;
    pent_q <= pent_d;
    res_q  <= res_d;
  end

  assign new_ent = '{id: req_q.task_id, prio: req_q.prio, state: req_q.task_state,
                     desc: req_q.desc_tag};

  // list match on the returned entry
  always_comb begin
    case (req_q.opcode)
      OP_LIST:  match = 1'b1;
      OP_GROUP: match = (rdata_i.state == grp_q);
      OP_PRIO:  match = (rdata_i.prio == req_q.prio);
      default:  match = 1'b0;
    endcase
  end

  // next state, memory access and result words
  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    count_d = count_q;
    cnt_d   = cnt_q;
    rv_d    = 1'b0;
    ridx_d  = ridx_q;
    found_d = found_q;
    fidx_d  = fidx_q;
    fent_d  = fent_q;
    posf_d  = posf_q;
    pos_d   = pos_q;
    grp_d   = grp_q;
    pend_d  = pend_q;
    pent_d  = pent_q;
    vld_d   = 1'b0;
    res_d   = '0;
    we_o    = 1'b0;
    waddr_o = '0;
    wdata_o = rdata_i;
    re_o    = 1'b0;
    raddr_o = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i && req_i.opcode <= OP_PRIO) begin
          req_d   = req_i;
          cnt_d   = '0;
          found_d = 1'b0;
          posf_d  = 1'b0;
          pend_d  = 1'b0;
          grp_d   = '0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // issue the next read
        if (cnt_q < count_q) begin
          re_o    = 1'b1;
          raddr_o = cnt_q[AW-1:0];
          ridx_d  = cnt_q[AW-1:0];
          rv_d    = 1'b1;
          cnt_d   = cnt_q + CW'(1);
        end
        // look at the entry read last cycle
        if (rv_q) begin
          if (req_q.opcode <= OP_UPDATE) begin
            if (!found_q && rdata_i.id == req_q.task_id) begin
              found_d = 1'b1;
              fidx_d  = ridx_q;
              fent_d  = rdata_i;
            end
            if (!posf_q && rdata_i.prio > req_q.prio) begin
              posf_d = 1'b1;
              pos_d  = CW'(ridx_q);
            end
          end else if (match) begin
            if (pend_q) begin
              vld_d = 1'b1;
              res_d = '{result_code: RC_OK, entry_valid: 1'b1, out_id: pent_q.id,
                        out_prio: pent_q.prio, out_state: pent_q.state,
                        out_desc: pent_q.desc, last: 1'b0};
            end
            pend_d = 1'b1;
            pent_d = rdata_i;
          end
        end else if (cnt_q >= count_q) begin
          // scan finished
          vld_d       = 1'b1;
          res_d.last  = 1'b1;
          state_d     = S_IDLE;
          case (req_q.opcode)
            OP_INSERT: begin
              if (found_q) begin
                res_d.result_code = RC_DUP;
              end else if (count_q == CW'(MAX_TASKS)) begin
                res_d.result_code = RC_FULL;
              end else begin
                vld_d   = 1'b0;
                cnt_d   = count_q;
                pos_d   = posf_q ? pos_q : count_q;
                state_d = S_SHUP;
              end
            end
            OP_DELETE: begin
              if (!found_q) begin
                res_d.result_code = RC_NOTF;
              end else begin
                vld_d   = 1'b0;
                cnt_d   = CW'(fidx_q) + CW'(1);
                state_d = S_SHDN;
              end
            end
            OP_UPDATE: begin
              if (!found_q) begin
                res_d.result_code = RC_NOTF;
              end else begin
                we_o          = 1'b1;
                waddr_o       = fidx_q;
                wdata_o       = fent_q;
                wdata_o.state = req_q.task_state;
              end
            end
            default: begin
              if (req_q.opcode == OP_GROUP && grp_q != ST_LAST_GROUP) begin
                // next status group
                vld_d   = 1'b0;
                grp_d   = grp_q + 2'd1;
                cnt_d   = '0;
                state_d = S_SCAN;
              end else if (pend_q) begin
                res_d = '{result_code: RC_OK, entry_valid: 1'b1, out_id: pent_q.id,
                          out_prio: pent_q.prio, out_state: pent_q.state,
                          out_desc: pent_q.desc, last: 1'b1};
              end else begin
                res_d.result_code = RC_NONE;
              end
            end
          endcase
        end
      end

      S_SHUP: begin
        // move entries one place up, from the top down to the gap
        if (cnt_q > pos_q) begin
          re_o    = 1'b1;
          raddr_o = AW'(cnt_q - CW'(1));
          ridx_d  = AW'(cnt_q - CW'(1));
          rv_d    = 1'b1;
          cnt_d   = cnt_q - CW'(1);
        end
        if (rv_q) begin
          we_o    = 1'b1;
          waddr_o = ridx_q + AW'(1);
          wdata_o = rdata_i;
        end else if (cnt_q <= pos_q) begin
          we_o       = 1'b1;
          waddr_o    = pos_q[AW-1:0];
          wdata_o    = new_ent;
          count_d    = count_q + CW'(1);
          vld_d      = 1'b1;
          res_d.last = 1'b1;
          state_d    = S_IDLE;
        end
      end

      S_SHDN: begin
        // move entries one place down over the removed one
        if (cnt_q < count_q) begin
          re_o    = 1'b1;
          raddr_o = cnt_q[AW-1:0];
          ridx_d  = cnt_q[AW-1:0];
          rv_d    = 1'b1;
          cnt_d   = cnt_q + CW'(1);
        end
        if (rv_q) begin
          we_o    = 1'b1;
          waddr_o = ridx_q - AW'(1);
          wdata_o = rdata_i;
        end else if (cnt_q >= count_q) begin
          count_d    = count_q - CW'(1);
          vld_d      = 1'b1;
          res_d.last = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/priority_sorted_task_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_sorted_task_table_top
// Task table kept sorted by ascending priority, with insert, delete, status
// update and three list operations.
// ----------------------------------------------------------------------------
// A command with a known opcode is taken when start_i is high and busy_o
// is low. Every command first reads the stored entries one per cycle
// through the single read port of the entry store; the grouped list reads
// the table three times, an insert then moves the entries above its place
// one each cycle, and a delete moves the entries above the removed one the
// same way. Each result word is shown for one cycle with res_valid_o and
// cannot be held off; a list ends with last set, and an empty table or no
// match gives a single word with the "none" code. No clearing pass is
// needed after reset.
module priority_sorted_task_table_top #(
  parameter int MAX_TASKS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  pstt_pkg::req_t req_i,
  output logic           busy_o,
  output logic           res_valid_o,
  output pstt_pkg::res_t res_o
);
  import pstt_pkg::*;

  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic          re;
  logic [AW-1:0] raddr;
  entry_t        rdata;

  // sequencer
  pstt_ctrl #(
    .MAX_TASKS (MAX_TASKS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  // entry store
  pstt_mem #(
    .DEPTH (MAX_TASKS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

// ===== rtl/pstt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstt_checker
// Port-level checks on the task table, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pstt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input pstt_pkg::req_t req_i,
  input logic           busy_o,
  input logic           res_valid_o,
  input pstt_pkg::res_t res_o
);
  import pstt_pkg::*;

  // an accepted valid command keeps the block busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.opcode <= OP_PRIO) |=> busy_o)
    else $error("no busy after accepted command");

  // a listed entry always carries the ok code
  a_entry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.entry_valid) |-> (res_o.result_code == RC_OK))
    else $error("listed entry with error code");

  // a word without an entry ends its command and carries zero fields
  a_plain_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.entry_valid) |->
      (res_o.last && res_o.out_id == '0 && res_o.out_desc == '0))
    else $error("bad plain result word");

  // no word arrives while idle, unless the block was busy in the previous cycle
  a_no_stray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && !$past(busy_o)) |-> !res_valid_o)
    else $error("result word while idle");

endmodule

bind priority_sorted_task_table_top pstt_checker u_pstt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .req_i       (req_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

// ===== sim/priority_sorted_task_table_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_sorted_task_table_top_test
// Drives insert, delete, update and list commands into the task table and
// checks every result word against a behavioural copy of the sorted table.
// ----------------------------------------------------------------------------
module priority_sorted_task_table_top_test;
  import pstt_pkg::*;

  localparam int TABLE_DEPTH   = 32;
  localparam int IDLE_LIMIT    = 4000;
  localparam int TAIL_CYCLES   = 120;
  localparam logic [2:0] OP_SPARE    = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // scoreboard holding a shadow of the sorted table
  class task_table_board;
    entry_t tbl[$];
    res_t   pending_words[$];
    int     errors;
    int     words_seen;

    function void push_word(logic [2:0] rc, entry_t e, logic valid);
      res_t r;
      r = '0;
      r.result_code = rc;
      r.entry_valid = valid;
      if (valid) begin
        r.out_id    = e.id;
        r.out_prio  = e.prio;
        r.out_state = e.state;
        r.out_desc  = e.desc;
      end
      r.last = 1'b0;
      pending_words.push_back(r);
    endfunction

    function int find_id(logic [15:0] id);
      for (int i = 0; i < tbl.size(); i++)
        if (tbl[i].id == id) return i;
      return -1;
    endfunction

    // note an accepted command and predict its words
    function void note_command(req_t q);
      entry_t e;
      int     f;
      int     pos;
      int     n;
      e = '0;
      n = 0;
      case (q.opcode)
        OP_INSERT: begin
          if (find_id(q.task_id) >= 0) push_word(RC_DUP, e, 1'b0);
          else if (tbl.size() >= TABLE_DEPTH) push_word(RC_FULL, e, 1'b0);
          else begin
            pos = 0;
            while (pos < tbl.size() && tbl[pos].prio <= q.prio) pos++;
            e.id = q.task_id; e.prio = q.prio;
            e.state = q.task_state; e.desc = q.desc_tag;
            tbl.insert(pos, e);
            push_word(RC_OK, '0, 1'b0);
          end
          n = 1;
        end
        OP_DELETE, OP_UPDATE: begin
          f = find_id(q.task_id);
          if (f < 0) push_word(RC_NOTF, e, 1'b0);
          else begin
            if (q.opcode == OP_DELETE) tbl.delete(f);
            else tbl[f].state = q.task_state;
            push_word(RC_OK, e, 1'b0);
          end
          n = 1;
        end
        OP_LIST, OP_GROUP, OP_PRIO: begin
          if (q.opcode == OP_GROUP) begin
            for (int g = 0; g <= int'(ST_LAST_GROUP); g++)
              for (int i = 0; i < tbl.size(); i++)
                if (tbl[i].state == g) begin
                  push_word(RC_OK, tbl[i], 1'b1); n++;
                end
          end else begin
            for (int i = 0; i < tbl.size(); i++)
              if (q.opcode == OP_LIST || tbl[i].prio == q.prio) begin
                push_word(RC_OK, tbl[i], 1'b1); n++;
              end
          end
          if (n == 0) begin
            push_word(RC_NONE, e, 1'b0); n = 1;
          end
        end
        default: ;
      endcase
      if (n > 0) pending_words[pending_words.size()-1].last = 1'b1;
    endfunction

    // compare one result word with the oldest prediction
    function void check_word(res_t a);
      res_t x;
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("unexpected result word %h", a);
        errors++;
        return;
      end
      x = pending_words.pop_front();
      if (a.result_code !== x.result_code) begin
        $error("result_code exp %0d got %0d", x.result_code, a.result_code); errors++;
      end
      if (a.entry_valid !== x.entry_valid) begin
        $error("entry_valid exp %0d got %0d", x.entry_valid, a.entry_valid); errors++;
      end
      if (a.out_id !== x.out_id) begin
        $error("out_id exp %h got %h", x.out_id, a.out_id); errors++;
      end
      if (a.out_prio !== x.out_prio) begin
        $error("out_prio exp %0d got %0d", x.out_prio, a.out_prio); errors++;
      end
      if (a.out_state !== x.out_state) begin
        $error("out_state exp %0d got %0d", x.out_state, a.out_state); errors++;
      end
      if (a.out_desc !== x.out_desc) begin
        $error("out_desc exp %h got %h", x.out_desc, a.out_desc); errors++;
      end
      if (a.last !== x.last) begin
        $error("last exp %0d got %0d", x.last, a.last); errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;

  task_table_board board;
  int idle_cycles;
  int commands_sent;
  int lists_sent;

  priority_sorted_task_table_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0; #10;
    clk_i = 1'b1; #10;
  end

  // result monitor and idle watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) board.check_word(res_o);
      if ((start_i && !busy_o) || res_valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("priority_sorted_task_table_top test failed");
        $finish;
      end
    end
  end

  // hand one command word to the block, holding it until taken;
  // start stays high so the next command can follow straight on
  task automatic send_command(req_t q);
    start_i <= 1'b1;
    req_i   <= q;
    do @(posedge clk_i); while (busy_o);
    board.note_command(q);
    commands_sent++;
    if (q.opcode inside {OP_LIST, OP_GROUP, OP_PRIO}) lists_sent++;
  endtask

  task automatic send_fields(logic [2:0] op, logic [15:0] id, logic [2:0] pr,
                             logic [1:0] st, logic [31:0] desc);
    req_t q;
    q.opcode = op; q.task_id = id; q.prio = pr;
    q.task_state = st; q.desc_tag = desc;
    send_command(q);
  endtask

  // drop start and let the clock run
  task automatic gap_cycles(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // wait for every predicted word, then let the block settle
  task automatic drain_results();
    gap_cycles(1);
    while (board.pending_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // random command, mostly on a small id pool so hits are common
  task automatic send_random();
    req_t q;
    int   pick;
    q = '0;
    pick = $urandom_range(0, 99);
    if (pick < 40) q.opcode = OP_INSERT;
    else if (pick < 55) q.opcode = OP_DELETE;
    else if (pick < 68) q.opcode = OP_UPDATE;
    else if (pick < 78) q.opcode = OP_LIST;
    else if (pick < 86) q.opcode = OP_GROUP;
    else if (pick < 96) q.opcode = OP_PRIO;
    else q.opcode = ($urandom_range(0, 1) == 0) ? OP_SPARE : OP_SPARE_HI;
    q.task_id    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    q.prio       = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(1, 5));
    q.task_state = 2'($urandom);
    q.desc_tag   = $urandom;
    send_command(q);
  endtask

  initial begin
    int burst;
    board = new();
    idle_cycles = 0;
    commands_sent = 0;
    lists_sent = 0;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty-table lists, misses, extremes, duplicate, full table
    send_fields(OP_LIST, 16'h0, 3'd1, 2'd0, 32'h0);
    send_fields(OP_GROUP, 16'h0, 3'd1, 2'd0, 32'h0);
    send_fields(OP_PRIO, 16'h0, 3'd3, 2'd0, 32'h0);
    send_fields(OP_DELETE, 16'h1234, 3'd1, 2'd0, 32'h0);
    send_fields(OP_UPDATE, 16'h1234, 3'd1, 2'd1, 32'h0);
    send_fields(OP_INSERT, 16'hFFFF, 3'd5, 2'd3, 32'hFFFF_FFFF);
    send_fields(OP_INSERT, 16'h0000, 3'd1, 2'd0, 32'h0000_0000);
    send_fields(OP_INSERT, 16'h0001, 3'd5, 2'd2, 32'hA5A5_5A5A);
    send_fields(OP_INSERT, 16'h0002, 3'd0, 2'd1, 32'h5A5A_A5A5);
    send_fields(OP_INSERT, 16'h0003, 3'd7, 2'd1, 32'h1);
    send_fields(OP_INSERT, 16'hFFFF, 3'd2, 2'd0, 32'h2);
    send_fields(OP_UPDATE, 16'h0000, 3'd1, 2'd2, 32'h0);
    send_fields(OP_GROUP, 16'h0, 3'd1, 2'd0, 32'h0);
    send_fields(OP_PRIO, 16'h0, 3'd5, 2'd0, 32'h0);
    send_fields(OP_PRIO, 16'h0, 3'd4, 2'd0, 32'h0);
    send_fields(OP_SPARE, 16'h0, 3'd1, 2'd0, 32'h0);
    send_fields(OP_SPARE_HI, 16'h0, 3'd1, 2'd0, 32'h0);
    send_fields(OP_DELETE, 16'h0002, 3'd1, 2'd0, 32'h0);
    send_fields(OP_LIST, 16'h0, 3'd1, 2'd0, 32'h0);
    // fill to the top, then one more
    for (int i = 0; i < TABLE_DEPTH - 4 + 1; i++)
      send_fields(OP_INSERT, 16'(16'h100 + i), 3'($urandom_range(1, 5)),
                  2'($urandom), $urandom);
    send_fields(OP_INSERT, 16'h0001, 3'd1, 2'd0, 32'h0);
    send_fields(OP_LIST, 16'h0, 3'd1, 2'd0, 32'h0);
    send_fields(OP_GROUP, 16'h0, 3'd1, 2'd0, 32'h0);
    // quiet pause until every word is in
    drain_results();
    for (int i = 0; i < TABLE_DEPTH + 4; i++)
      send_fields(OP_DELETE, 16'(16'h100 + i), 3'd1, 2'd0, 32'h0);

    // random bursts with random gaps
    while (commands_sent < 170) begin
      burst = $urandom_range(1, 12);
      repeat (burst) send_random();
      if ($urandom_range(0, 2) != 0) gap_cycles($urandom_range(1, 40));
      if ($urandom_range(0, 15) == 0) drain_results();
    end

    drain_results();
    $display("ran %0d commands, %0d of them lists, and checked %0d result words",
             commands_sent, lists_sent, board.words_seen);
    if (board.errors == 0 && board.pending_words.size() == 0)
      $display("priority_sorted_task_table_top test passed");
    else
      $display("priority_sorted_task_table_top test failed");
    $finish;
  end

endmodule
